// ===== rtl/core/bisp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bisp_pkg: shared types and constants of the binary IR stream parser
// Holds result kinds, parse phases, status codes, the magic word, the
// result record layout and the sizing of the result queue.
// ----------------------------------------------------------------------------
package bisp_pkg;

  localparam int unsigned BISP_LENGTH_BITS = 36;  // default byte counter width

  localparam int unsigned HDR_BYTES  = 16;
  localparam int unsigned REC_BYTES  = 8;
  localparam int unsigned EXP_W      = 36;         // holds 16 + 9 * (2^32 - 1)

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_OUTPUT = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RECORD = 2'd1,
    PH_OUTPUT = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  localparam logic [31:0] ST_OK        = 32'd0;
  localparam logic [31:0] ST_SHORT     = 32'd1;
  localparam logic [31:0] ST_BAD_MAGIC = 32'd2;
  localparam logic [31:0] ST_MISMATCH  = 32'd3;

  localparam logic [3:0][7:0] MAGIC = {8'h4C, 8'h4D, 8'h52, 8'h43};

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  opcode;
    logic [7:0]  dst;
    logic [7:0]  src0;
    logic [7:0]  src1;
    logic [7:0]  aux0;
    logic [7:0]  aux1;
    logic [7:0]  level;
    logic [7:0]  record_flags;
    logic [63:0] wide_a;
    logic [31:0] wide_b;
    logic        run_end;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/binary_ir_stream_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// binary_ir_stream_parser: byte-serial parser for a serialized IR module
// Takes one module byte per request and returns header, instruction record,
// output entry and final status results through a small result queue.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  input   | in        | in_valid_i / in_ready_o | data_byte_i, end_of_stream_i
//  result  | out       | out_valid_o/out_ready_i | kind_o .. wide_b_o, run_end_o
//
//  Cycles: one byte per cycle while in_ready_o is high. Each accepted byte
//  is decoded in the cycle it arrives and its results (zero, one or two)
//  are written into a 4-entry result queue; the queue drains one result per
//  cycle while out_ready_i is high, so a byte that produces two results (a
//  result plus the final status) leaves the queue as two separate entries.
//  Reset: rst_ni clears the parse state and empties the queue; the parser
//  also returns to its reset state after every final status.
//  Stalls: in_ready_o stays high while the queue has room for two results,
//  independent of out_ready_i in the cycle itself.
//
module binary_ir_stream_parser
  import bisp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = BISP_LENGTH_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       opcode_o,
  output logic [7:0]       dst_o,
  output logic [7:0]       src0_o,
  output logic [7:0]       src1_o,
  output logic [7:0]       aux0_o,
  output logic [7:0]       aux1_o,
  output logic [7:0]       level_o,
  output logic [7:0]       record_flags_o,
  output logic [63:0]      wide_a_o,
  output logic [31:0]      wide_b_o,
  output logic             run_end_o
);

  localparam int unsigned CMP_W = (LENGTH_BITS > EXP_W) ? LENGTH_BITS : EXP_W;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] bytes_q, bytes_d;   // position of the next byte
  logic                   magic_ok_q, magic_ok_d;
  logic [31:0]            rec_idx_q, rec_idx_d;
  logic [31:0]            out_idx_q, out_idx_d;

  // Header fields and record bytes: payload, written before they are read
  logic [31:0]            vf_q;               // flags << 16 | version
  logic [31:0]            ic_q;               // instruction count
  logic [31:0]            oc_q;               // output count
  logic [EXP_W-1:0]       expect_q;           // expected total length
  logic [6:0][7:0]        rec_q;              // first seven bytes of a record

  logic                   in_fire;
  logic [LENGTH_BITS-1:0] bytes_inc;
  logic [31:0]            oc_new;
  logic                   hdr_last;
  logic                   mismatch;
  logic                   push_a;
  logic                   push_b;
  result_t                res_a;
  result_t                res_b;

  assign in_fire   = in_valid_i && in_ready_o;
  // Saturate the byte count at its top value
  assign bytes_inc = (bytes_q == COUNT_MAX) ? bytes_q : bytes_q + 1'b1;
  // Output count as it stands once the current byte is in
  assign oc_new    = {data_byte_i, oc_q[23:0]};
  assign hdr_last  = (phase_q == PH_HEADER) && (bytes_q[3:0] == 4'(HDR_BYTES - 1));

  // Length check: a saturated count always mismatches; on the last header byte
  // 16 is expected iff both counts are zero; later bytes check the stored total.
  always_comb begin
    if (bytes_inc == COUNT_MAX) begin
      mismatch = 1'b1;
    end else if (hdr_last) begin
      mismatch = (ic_q != 32'd0) || (oc_new != 32'd0);
    end else begin
      mismatch = CMP_W'(bytes_inc) != CMP_W'(expect_q);
    end
  end

  // Next state and the results caused by the current byte
  always_comb begin
    phase_d    = phase_q;
    bytes_d    = bytes_inc;
    magic_ok_d = magic_ok_q;
    rec_idx_d  = rec_idx_q;
    out_idx_d  = out_idx_q;
    push_a     = 1'b0;
    res_a      = '0;
    res_b      = '0;

    unique case (phase_q)
      PH_HEADER: begin
        // Check the magic word on the first four bytes
        if ((bytes_q < LENGTH_BITS'(4)) && (data_byte_i != MAGIC[bytes_q[1:0]])) begin
          magic_ok_d = 1'b0;
        end
        if (hdr_last) begin
          push_a        = 1'b1;
          res_a.kind    = KIND_HEADER;
          res_a.wide_a  = {oc_new, ic_q};
          res_a.wide_b  = vf_q;
          // Skip empty sections
          if (ic_q != 32'd0) begin
            phase_d = PH_RECORD;
          end else if (oc_new != 32'd0) begin
            phase_d = PH_OUTPUT;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
      PH_RECORD: begin
        // Emit on the eighth byte of a record; a saturated count lands here too
        if (bytes_q[2:0] == 3'(REC_BYTES - 1)) begin
          push_a             = 1'b1;
          res_a.kind         = KIND_RECORD;
          res_a.opcode       = rec_q[0];
          res_a.dst          = rec_q[1];
          res_a.src0         = rec_q[2];
          res_a.src1         = rec_q[3];
          res_a.aux0         = rec_q[4];
          res_a.aux1         = rec_q[5];
          res_a.level        = rec_q[6];
          res_a.record_flags = data_byte_i;
          rec_idx_d          = rec_idx_q + 32'd1;
          if (rec_idx_d == ic_q) begin
            phase_d = (oc_q != 32'd0) ? PH_OUTPUT : PH_DONE;
          end
        end
      end
      PH_OUTPUT: begin
        push_a       = 1'b1;
        res_a.kind   = KIND_OUTPUT;
        res_a.dst    = data_byte_i;
        res_a.wide_a = {32'd0, out_idx_q};
        out_idx_d    = out_idx_q + 32'd1;
        if (out_idx_d == oc_q) begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        // Trailing bytes: count only
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    res_a.run_end = !end_of_stream_i;

    if (end_of_stream_i) begin
      res_b.kind    = KIND_STATUS;
      res_b.wide_a  = 64'(bytes_inc);
      res_b.run_end = 1'b1;
      // Too short wins over bad magic, which wins over a length mismatch
      if (bytes_inc < LENGTH_BITS'(HDR_BYTES)) begin
        res_b.wide_b = ST_SHORT;
      end else if (!magic_ok_d) begin
        res_b.wide_b = ST_BAD_MAGIC;
      end else if (mismatch) begin
        res_b.wide_b = ST_MISMATCH;
      end else begin
        res_b.wide_b = ST_OK;
      end
      // Drop all state, ready for the next module
      phase_d    = PH_HEADER;
      bytes_d    = '0;
      magic_ok_d = 1'b1;
      rec_idx_d  = '0;
      out_idx_d  = '0;
    end
  end

  assign push_b = end_of_stream_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      bytes_q    <= '0;
      magic_ok_q <= 1'b1;
      rec_idx_q  <= '0;
      out_idx_q  <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      bytes_q    <= bytes_d;
      magic_ok_q <= magic_ok_d;
      rec_idx_q  <= rec_idx_d;
      out_idx_q  <= out_idx_d;
    end
  end

  // Capture header fields and record bytes as they stream by
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (phase_q == PH_HEADER) begin
        unique case (bytes_q[3:2])
          2'd1:    vf_q[8*bytes_q[1:0] +: 8] <= data_byte_i;
          2'd2:    ic_q[8*bytes_q[1:0] +: 8] <= data_byte_i;
          2'd3:    oc_q[8*bytes_q[1:0] +: 8] <= data_byte_i;
          default: ;
        endcase
        if (hdr_last) begin
          expect_q <= EXP_W'(HDR_BYTES) + ({4'd0, ic_q} << 3) + EXP_W'(oc_new);
        end
      end
      if ((phase_q == PH_RECORD) && (bytes_q[2:0] != 3'(REC_BYTES - 1))) begin
        rec_q[bytes_q[2:0]] <= data_byte_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two writes per byte, one read per cycle if out_ready_i
  // --------------------------------------------------------------------------
  result_t              fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [PTR_W-1:0]     slot_b;
  logic [1:0]           n_push;
  logic                 do_a;
  logic                 do_b;
  logic                 out_fire;

  assign do_a     = in_fire && push_a;
  assign do_b     = in_fire && push_b;
  assign n_push   = {1'b0, do_a} + {1'b0, do_b};
  assign slot_b   = wr_ptr_q + PTR_W'(do_a);
  assign out_fire = out_valid_o && out_ready_i;

  // Hold off input unless two slots are free
  assign in_ready_o  = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;

  always_ff @(posedge clk_i) begin
    if (do_a) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (do_b) begin
      fifo_q[slot_b] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + PTR_W'(out_fire);
      cnt_q    <= cnt_q + CNT_W'(n_push) - CNT_W'(out_fire);
    end
  end

  result_t head;
  assign head = fifo_q[rd_ptr_q];

  assign kind_o         = head.kind;
  assign opcode_o       = head.opcode;
  assign dst_o          = head.dst;
  assign src0_o         = head.src0;
  assign src1_o         = head.src1;
  assign aux0_o         = head.aux0;
  assign aux1_o         = head.aux1;
  assign level_o        = head.level;
  assign record_flags_o = head.record_flags;
  assign wide_a_o       = head.wide_a;
  assign wide_b_o       = head.wide_b;
  assign run_end_o      = head.run_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_STATUS) |-> run_end_o)
    else $error("status result without run_end");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_stream_i |=> (phase_q == PH_HEADER) && (bytes_q == '0)
      && magic_ok_q)
    else $error("parser did not restart after final byte");

  a_records_need_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == PH_RECORD) |-> ic_q != 32'd0)
    else $error("record phase entered with zero instruction count");

  a_two_results_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> cnt_q + CNT_W'(n_push) <= CNT_W'(FIFO_DEPTH))
    else $error("accepted byte overruns result queue");

endmodule
`default_nettype wire
